// File: src/cascaded_angle_rate_pid_defines.svh
// assertion macros for the cascaded angle/rate controller
`ifndef CASCADED_ANGLE_RATE_PID_DEFINES_SVH
`define CASCADED_ANGLE_RATE_PID_DEFINES_SVH
`ifndef SYNTHESIS
`define CARP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CARP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CARP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CARP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/carp_pkg.sv
`timescale 1ns / 1ps
package carp_pkg;
	localparam int unsigned GAIN_W = 31;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DT_W = 24;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned IDX_W = 3;

	typedef enum logic [2:0] {
		REG_OUTER_ERROR_GAIN  = 3'd0,
		REG_OUTER_INTEGRAL_GAIN = 3'd1,
		REG_OUTER_RATE_GAIN   = 3'd2,
		REG_OUTER_INT_LIMIT   = 3'd3,
		REG_OUTER_OUT_LIMIT   = 3'd4,
		REG_INNER_ERROR_GAIN  = 3'd5,
		REG_INNER_INTEGRAL_GAIN = 3'd6,
		REG_INNER_DERIV_GAIN  = 3'd7
	} reg_idx_t;

	// sequencer states; each MUL/DIV state runs the shared bit-serial unit
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_O_INT,
		ST_O_P,
		ST_O_I,
		ST_O_R,
		ST_O_SUM,
		ST_I_INT,
		ST_DIV,
		ST_I_P,
		ST_I_I,
		ST_I_D,
		ST_I_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] angle_ref;
		logic signed [DATA_W-1:0] angle_meas;
		logic signed [DATA_W-1:0] rate_meas;
		logic [DT_W-1:0]          time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive_value;
		logic signed [DATA_W-1:0] rate_setpoint;
	} out_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] data;
	} cfg_item_t;
endpackage

// File: src/carp_in_if.sv
`timescale 1ns / 1ps
interface carp_in_if;
	logic valid;
	logic ready;
	carp_pkg::in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: src/carp_out_if.sv
`timescale 1ns / 1ps
interface carp_out_if;
	logic valid;
	logic ready;
	carp_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: src/carp_cfg_if.sv
`timescale 1ns / 1ps
interface carp_cfg_if;
	logic valid;
	logic ready;
	carp_pkg::cfg_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: src/cascaded_angle_rate_pid.sv
`timescale 1ns / 1ps
// sequence: after an input transfer one bit-serial unit runs six gain multiplies over the
// 32-bit multiplier operand, two time step multiplies over the 24-bit time step and a
// 64-bit divide, plus two sum states and an output state, before the result is valid
// one item at a time, accepted in idle; the next input is taken while a result waits
// a result still waiting holds the following item at its final sum until it transfers
// reset: arst_n clears registers, integrals, previous rate and control state to zero
`include "cascaded_angle_rate_pid_defines.svh"
module cascaded_angle_rate_pid #(
	parameter int unsigned INNER_INTEGRAL_LIMIT = 6553600
) (
	input  logic clk,
	input  logic arst_n,
	carp_in_if.sink    in_ch,
	carp_out_if.source out_ch,
	carp_cfg_if.sink   cfg
);
	localparam int unsigned W = carp_pkg::DATA_W;
	localparam int unsigned AW = 72;    // wide accumulator
	localparam int unsigned CW = 7;

	logic [carp_pkg::GAIN_W-1:0] regs_q [carp_pkg::NUM_REGS];
	logic signed [W-1:0] o_int_q, i_int_q, prev_q;
	logic signed [W-1:0] rate_q;
	logic [carp_pkg::DT_W-1:0] dt_q;
	logic signed [W:0] err_q;                // 33-bit error
	logic signed [AW-1:0] sum_q;             // term accumulator
	logic signed [W-1:0] setp_q, deriv_q;
	carp_pkg::state_t state_q, state_d;
	logic out_valid_q;
	carp_pkg::out_item_t out_q;

	// bit-serial multiplier: multiplicand sign-extended, multiplier unsigned shift
	logic signed [AW-1:0] mcand_q, prod_q;
	logic [W-1:0] mplier_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, start;
	logic signed [AW-1:0] mul_a;
	logic [W-1:0] mul_b;
	logic [CW-1:0] mul_len;
	// restoring divider on magnitudes
	logic [63:0] dquo_q;
	logic [23:0] drem_q;
	logic div_neg_q;

	logic in_fire, done, out_free, out_stall;
	logic signed [W+1:0] diff;
	logic [63:0] dnum;
	logic [24:0] drem_sh;
	logic signed [AW-1:0] prod_floor;
	logic signed [W+1:0] int_sum;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == carp_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_stall = out_valid_q && !out_ch.ready;
	assign diff = (W+2)'(prev_q) - (W+2)'(rate_q);
	assign dnum = diff[W+1] ? 64'(-diff) << carp_pkg::DT_W : 64'(diff) << carp_pkg::DT_W;
	assign done = busy_q && (cnt_q == '0);

	// operand select for the shared unit
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_len = CW'(W);
		case (state_q)
			carp_pkg::ST_O_INT: begin
				mul_a = AW'(err_q); mul_b = W'(dt_q); mul_len = CW'(carp_pkg::DT_W);
			end
			carp_pkg::ST_O_P: begin
				mul_a = AW'(err_q); mul_b = W'(regs_q[carp_pkg::REG_OUTER_ERROR_GAIN]);
			end
			carp_pkg::ST_O_I: begin
				mul_a = AW'(o_int_q); mul_b = W'(regs_q[carp_pkg::REG_OUTER_INTEGRAL_GAIN]);
			end
			carp_pkg::ST_O_R: begin
				mul_a = -AW'(rate_q); mul_b = W'(regs_q[carp_pkg::REG_OUTER_RATE_GAIN]);
			end
			carp_pkg::ST_I_INT: begin
				// inner error straight from the setpoint, err_q catches up on this cycle
				mul_a = AW'(setp_q) - AW'(rate_q); mul_b = W'(dt_q);
				mul_len = CW'(carp_pkg::DT_W);
			end
			carp_pkg::ST_I_P: begin
				mul_a = AW'(err_q); mul_b = W'(regs_q[carp_pkg::REG_INNER_ERROR_GAIN]);
			end
			carp_pkg::ST_I_I: begin
				mul_a = AW'(i_int_q); mul_b = W'(regs_q[carp_pkg::REG_INNER_INTEGRAL_GAIN]);
			end
			carp_pkg::ST_I_D: begin
				mul_a = AW'(deriv_q); mul_b = W'(regs_q[carp_pkg::REG_INNER_DERIV_GAIN]);
			end
			carp_pkg::ST_DIV: mul_len = CW'(64);
			default: ;
		endcase
	end

	assign start = !busy_q && state_q != carp_pkg::ST_IDLE && state_q != carp_pkg::ST_O_SUM
		&& state_q != carp_pkg::ST_I_SUM && state_q != carp_pkg::ST_OUT;
	assign drem_sh = {drem_q, dquo_q[63]};

	// shared serial unit: one partial product or one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= mul_len;
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mul_a;
			mplier_q <= mul_b;
			prod_q <= '0;
			dquo_q <= dnum;
			drem_q <= '0;
			div_neg_q <= diff[W+1];
		end else if (busy_q && cnt_q != '0) begin
			if (mplier_q[0]) prod_q <= prod_q + mcand_q;
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
			if (drem_sh >= {1'b0, dt_q}) begin
				drem_q <= 24'(drem_sh - {1'b0, dt_q});
				dquo_q <= {dquo_q[62:0], 1'b1};
			end else begin
				drem_q <= drem_sh[23:0];
				dquo_q <= {dquo_q[62:0], 1'b0};
			end
		end
	end

	// gain product divided by 2^16, floored
	assign prod_floor = prod_q >>> 16;
	always_comb begin
		if (state_q == carp_pkg::ST_O_INT)
			int_sum = (W+2)'(o_int_q) + (W+2)'(prod_q >>> carp_pkg::DT_W);
		else
			int_sum = (W+2)'(i_int_q) + (W+2)'(prod_q >>> carp_pkg::DT_W);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			carp_pkg::ST_IDLE:  if (in_fire) state_d = carp_pkg::ST_O_INT;
			carp_pkg::ST_O_INT: if (done) state_d = carp_pkg::ST_O_P;
			carp_pkg::ST_O_P:   if (done) state_d = carp_pkg::ST_O_I;
			carp_pkg::ST_O_I:   if (done) state_d = carp_pkg::ST_O_R;
			carp_pkg::ST_O_R:   if (done) state_d = carp_pkg::ST_O_SUM;
			carp_pkg::ST_O_SUM: state_d = carp_pkg::ST_I_INT;
			carp_pkg::ST_I_INT: if (done) state_d = carp_pkg::ST_DIV;
			carp_pkg::ST_DIV:   if (done) state_d = carp_pkg::ST_I_P;
			carp_pkg::ST_I_P:   if (done) state_d = carp_pkg::ST_I_I;
			carp_pkg::ST_I_I:   if (done) state_d = carp_pkg::ST_I_D;
			carp_pkg::ST_I_D:   if (done) state_d = carp_pkg::ST_I_SUM;
			carp_pkg::ST_I_SUM: if (out_free) state_d = carp_pkg::ST_OUT;
			carp_pkg::ST_OUT:   state_d = carp_pkg::ST_IDLE;
			default: state_d = carp_pkg::ST_IDLE;
		endcase
	end

	// control state, configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= carp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			o_int_q <= '0;
			i_int_q <= '0;
			prev_q <= '0;
			for (int i = 0; i < carp_pkg::NUM_REGS; i++) regs_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid)
				regs_q[cfg.payload.index] <= cfg.payload.data[carp_pkg::GAIN_W-1:0];
			if (state_q == carp_pkg::ST_OUT) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (done && state_q == carp_pkg::ST_O_INT) begin
				if (int_sum > (W+2)'(signed'({1'b0, regs_q[carp_pkg::REG_OUTER_INT_LIMIT]})))
					o_int_q <= W'({1'b0, regs_q[carp_pkg::REG_OUTER_INT_LIMIT]});
				else if (int_sum
					< -(W+2)'(signed'({1'b0, regs_q[carp_pkg::REG_OUTER_INT_LIMIT]})))
					o_int_q <= -W'({1'b0, regs_q[carp_pkg::REG_OUTER_INT_LIMIT]});
				else o_int_q <= W'(int_sum);
			end
			if (done && state_q == carp_pkg::ST_I_INT) begin
				if (int_sum > signed'((W+2)'(INNER_INTEGRAL_LIMIT)))
					i_int_q <= W'(INNER_INTEGRAL_LIMIT);
				else if (int_sum < -signed'((W+2)'(INNER_INTEGRAL_LIMIT)))
					i_int_q <= -W'(INNER_INTEGRAL_LIMIT);
				else i_int_q <= W'(int_sum);
			end
			if (state_q == carp_pkg::ST_OUT)
				prev_q <= rate_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rate_q <= in_ch.payload.rate_meas;
			dt_q <= in_ch.payload.time_step;
			err_q <= (W+1)'(in_ch.payload.angle_ref) - (W+1)'(in_ch.payload.angle_meas);
			sum_q <= '0;
		end
		if (done) begin
			case (state_q)
				carp_pkg::ST_O_P, carp_pkg::ST_O_I, carp_pkg::ST_O_R,
				carp_pkg::ST_I_P, carp_pkg::ST_I_I, carp_pkg::ST_I_D:
					sum_q <= sum_q + prod_floor;
				carp_pkg::ST_DIV: begin
					if (dt_q == '0)
						deriv_q <= diff[W+1] ? {1'b1, {(W-1){1'b0}}}
							: (diff == '0 ? '0 : {1'b0, {(W-1){1'b1}}});
					else if (!div_neg_q && dquo_q > 64'h7FFF_FFFF)
						deriv_q <= {1'b0, {(W-1){1'b1}}};
					else if (div_neg_q && dquo_q > 64'h8000_0000)
						deriv_q <= {1'b1, {(W-1){1'b0}}};
					else
						deriv_q <= div_neg_q ? W'(-dquo_q) : W'(dquo_q);
				end
				default: ;
			endcase
		end
		if (state_q == carp_pkg::ST_O_SUM) begin
			if (sum_q > AW'(signed'({1'b0, regs_q[carp_pkg::REG_OUTER_OUT_LIMIT]})))
				setp_q <= W'({1'b0, regs_q[carp_pkg::REG_OUTER_OUT_LIMIT]});
			else if (sum_q < -AW'(signed'({1'b0, regs_q[carp_pkg::REG_OUTER_OUT_LIMIT]})))
				setp_q <= -W'({1'b0, regs_q[carp_pkg::REG_OUTER_OUT_LIMIT]});
			else setp_q <= W'(sum_q);
			sum_q <= '0;
		end
		if (state_q == carp_pkg::ST_I_INT && !busy_q)
			err_q <= (W+1)'(setp_q) - (W+1)'(rate_q);
		// result register loads only once the previous result has gone
		if (state_q == carp_pkg::ST_I_SUM && out_free) begin
			out_q.rate_setpoint <= setp_q;
			if (sum_q > AW'(32'sh7FFF_FFFF)) out_q.drive_value <= 32'sh7FFF_FFFF;
			else if (sum_q < -AW'(33'sh0_8000_0000)) out_q.drive_value <= 32'sh8000_0000;
			else out_q.drive_value <= W'(sum_q);
		end
	end

	`CARP_ASSERT_IMP(a_no_in_when_busy, clk, arst_n, in_fire, state_q == carp_pkg::ST_IDLE)
	`CARP_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, out_valid_q && $stable(out_q))
	`CARP_ASSERT_IMP(a_iint_bound, clk, arst_n, 1'b1, (i_int_q <= signed'(W'(INNER_INTEGRAL_LIMIT))) && (i_int_q >= -signed'(W'(INNER_INTEGRAL_LIMIT))))
	`CARP_ASSERT_NXT(a_out_after_seq, clk, arst_n, state_q == carp_pkg::ST_OUT, out_valid_q)
endmodule

// File: dv/cascaded_angle_rate_pid_checker.sv
`timescale 1ns / 1ps
module cascaded_angle_rate_pid_checker #(
	parameter longint INNER_INT_LIMIT = 6553600
) (
	input  logic clk,
	input  logic arst_n,
	carp_in_if   in_ch,
	carp_out_if  out_ch,
	carp_cfg_if  cfg,
	output int   mismatches,
	output int   outstanding,
	output int   results_seen
);
	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;

	logic [carp_pkg::GAIN_W-1:0] gains [carp_pkg::NUM_REGS];
	longint angle_integral;
	longint rate_integral;
	longint last_rate;
	carp_pkg::out_item_t expected_q [$];

	function automatic longint clamp_sym(longint x, longint lim);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	function automatic longint sat32(longint x);
		if (x > MAX32)
			return MAX32;
		if (x < MIN32)
			return MIN32;
		return x;
	endfunction

	// gain times value, floor of the product with a Q15.16 gain
	function automatic longint scaled(carp_pkg::reg_idx_t idx, longint v);
		longint g;
		g = longint'({33'b0, gains[idx]});
		return (g * v) >>> 16;
	endfunction

	// one control step: updates the loop state, returns drive and setpoint
	function automatic carp_pkg::out_item_t control_step(carp_pkg::in_item_t it);
		longint tgt, ang, rate, dt, err, sum, setpoint, diff, deriv, drive;
		carp_pkg::out_item_t res;
		tgt = longint'(it.angle_ref);
		ang = longint'(it.angle_meas);
		rate = longint'(it.rate_meas);
		dt = longint'({40'b0, it.time_step});

		// outer angle loop
		err = tgt - ang;
		angle_integral = clamp_sym(angle_integral + ((err * dt) >>> 24),
			longint'({33'b0, gains[carp_pkg::REG_OUTER_INT_LIMIT]}));
		sum = scaled(carp_pkg::REG_OUTER_ERROR_GAIN, err)
			+ scaled(carp_pkg::REG_OUTER_INTEGRAL_GAIN, angle_integral)
			+ scaled(carp_pkg::REG_OUTER_RATE_GAIN, -rate);
		setpoint = clamp_sym(sum, longint'({33'b0, gains[carp_pkg::REG_OUTER_OUT_LIMIT]}));

		// inner rate loop
		err = setpoint - rate;
		rate_integral = clamp_sym(rate_integral + ((err * dt) >>> 24), INNER_INT_LIMIT);
		diff = last_rate - rate;
		if (dt == 0)
			deriv = (diff > 0) ? MAX32 : (diff < 0) ? MIN32 : 0;
		else
			deriv = sat32((diff * 64'sd16777216) / dt);
		last_rate = rate;

		drive = sat32(scaled(carp_pkg::REG_INNER_ERROR_GAIN, err)
			+ scaled(carp_pkg::REG_INNER_INTEGRAL_GAIN, rate_integral)
			+ scaled(carp_pkg::REG_INNER_DERIV_GAIN, deriv));
		res.drive_value = drive[31:0];
		res.rate_setpoint = setpoint[31:0];
		return res;
	endfunction

	assign outstanding = expected_q.size();

	// track register writes, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		carp_pkg::out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < carp_pkg::NUM_REGS; i++)
				gains[i] = '0;
			angle_integral = 0;
			rate_integral = 0;
			last_rate = 0;
			expected_q.delete();
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				gains[cfg.payload.index] = cfg.payload.data[carp_pkg::GAIN_W-1:0];
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing pending: drive %h setpoint %h",
						$time, out_ch.payload.drive_value, out_ch.payload.rate_setpoint);
				end else begin
					want = expected_q.pop_front();
					if (out_ch.payload.drive_value !== want.drive_value) begin
						mismatches++;
						$display("%0t: drive_value expected %h actual %h", $time,
							want.drive_value, out_ch.payload.drive_value);
					end
					if (out_ch.payload.rate_setpoint !== want.rate_setpoint) begin
						mismatches++;
						$display("%0t: rate_setpoint expected %h actual %h", $time,
							want.rate_setpoint, out_ch.payload.rate_setpoint);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_q.push_back(control_step(in_ch.payload));
		end
	end
endmodule

// File: dv/cascaded_angle_rate_pid_tb.sv
`timescale 1ns / 1ps
module cascaded_angle_rate_pid_tb;
	localparam int HOLD_CYCLES = 3000;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int mismatches, outstanding, results_seen;
	int items_sent = 0;
	int settings_used = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;
	int holds_done = 0;
	longint cycles = 0;

	carp_in_if  in_ch ();
	carp_out_if out_ch ();
	carp_cfg_if cfg ();

	cascaded_angle_rate_pid dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	cascaded_angle_rate_pid_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.cfg          (cfg),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, outstanding);
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: changing stall patterns, plus one long hold-off on request
	initial begin
		int mode, tick;
		mode = 0;
		tick = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else begin
				if (tick == 0) begin
					mode = $urandom_range(0, 3);
					tick = $urandom_range(16, 400);
				end
				tick--;
				case (mode)
					0: out_ch.ready = 1'b1;
					1: out_ch.ready = ($urandom_range(0, 3) != 0);
					2: out_ch.ready = ($urandom_range(0, 3) == 0);
					default: out_ch.ready = ~out_ch.ready;
				endcase
			end
		end
	end

	// one input transfer, with bursts and random gaps in between
	task automatic offer_item(carp_pkg::in_item_t it);
		if (burst_left == 0) begin
			if ($urandom_range(0, 4) != 0) begin
				in_ch.valid = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 12);
		end
		in_ch.valid = 1'b1;
		in_ch.payload = it;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	// let every pending result drain before touching registers
	task automatic settle();
		in_ch.valid = 1'b0;
		burst_left = 0;
		wait (outstanding == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(carp_pkg::reg_idx_t idx, logic [31:0] value);
		cfg.valid = 1'b1;
		cfg.payload.index = idx;
		cfg.payload.data = value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic load_all(logic [31:0] gain, logic [31:0] limit);
		settle();
		write_reg(carp_pkg::REG_OUTER_ERROR_GAIN, gain);
		write_reg(carp_pkg::REG_OUTER_INTEGRAL_GAIN, gain);
		write_reg(carp_pkg::REG_OUTER_RATE_GAIN, gain);
		write_reg(carp_pkg::REG_OUTER_INT_LIMIT, limit);
		write_reg(carp_pkg::REG_OUTER_OUT_LIMIT, limit);
		write_reg(carp_pkg::REG_INNER_ERROR_GAIN, gain);
		write_reg(carp_pkg::REG_INNER_INTEGRAL_GAIN, gain);
		write_reg(carp_pkg::REG_INNER_DERIV_GAIN, gain);
		settings_used++;
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return $urandom();
			default: return $urandom_range(0, 32'h0004_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_limit();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return $urandom();
			2: return 32'h7FFF_FFFF;
			default: return $urandom_range(32'h0001_0000, 32'h0640_0000);
		endcase
	endfunction

	task automatic load_random();
		settle();
		for (int i = 0; i < carp_pkg::NUM_REGS; i++)
			write_reg(carp_pkg::reg_idx_t'(i),
				(i == carp_pkg::REG_OUTER_INT_LIMIT || i == carp_pkg::REG_OUTER_OUT_LIMIT)
				? rand_limit() : rand_gain());
		settings_used++;
	endtask

	// mostly small realistic values, sometimes anything
	function automatic logic [31:0] rand_value();
		if ($urandom_range(0, 9) < 6)
			return $urandom_range(0, 13107200) - 32'd6553600;
		return $urandom();
	endfunction

	function automatic logic [23:0] rand_step();
		case ($urandom_range(0, 9))
			6: return 24'($urandom_range(1, 24'hFF_FFFF));
			7: return 24'd1;
			8: return 24'hFF_FFFF;
			9: return 24'($urandom());
			default: return 24'($urandom_range(1000, 70000));
		endcase
	endfunction

	task automatic run_random(int count);
		carp_pkg::in_item_t it;
		for (int n = 0; n < count; n++) begin
			it.angle_ref = rand_value();
			it.angle_meas = rand_value();
			it.rate_meas = rand_value();
			it.time_step = rand_step();
			offer_item(it);
		end
	endtask

	// field extremes and the zero time step cases
	task automatic run_directed();
		offer_item('{32'sh0, 32'sh0, 32'sh0, 24'd16777});
		offer_item('{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0, 24'hFF_FFFF});
		offer_item('{-32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFF_FFFF});
		offer_item('{32'sh0001_0000, 32'sh0, -32'sh8000_0000, 24'd1});
		offer_item('{32'sh0, 32'sh0, 32'sh0010_0000, 24'd0});
		offer_item('{32'sh0, 32'sh0, 32'sh0, 24'd0});
		offer_item('{32'sh0, 32'sh0, 32'sh0, 24'd0});
		offer_item('{32'sh0, 32'sh0, 32'sh7FFF_FFFF, 24'd1});
		offer_item('{32'sh0, 32'sh0, -32'sh8000_0000, 24'd1});
		offer_item('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'd0});
		offer_item('{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 24'd1});
		offer_item('{32'shFFFF_FFFF, 32'sh0, 32'shFFFF_FFFF, 24'h80_0000});
		offer_item('{32'sh5A5A_5A5A, 32'shA5A5_A5A5, 32'sh0F0F_0F0F, 24'h55_5555});
		offer_item('{32'shA5A5_A5A5, 32'sh5A5A_5A5A, 32'shF0F0_F0F0, 24'hAA_AAAA});
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		cfg.valid = 1'b0;
		cfg.payload = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// registers at reset value
		run_directed();
		// moderate gains, wide limits
		load_all(32'h0001_8000, 32'h0640_0000);
		run_directed();
		// every register at its maximum, top data bit set to check masking
		load_all(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_directed();
		// limits at zero with large gains
		load_all(32'h7FFF_FFFF, 32'h0);
		run_directed();

		for (int phase = 0; phase < 8; phase++) begin
			load_random();
			if (phase == 2)
				hold_req = 1'b1;
			run_random(210);
		end

		settle();
		repeat (500) @(posedge clk);
		$display("covered %0d items and %0d results over %0d register settings",
			items_sent, results_seen, settings_used + 1);
		$display("including zero and extreme time steps and %0d long output hold-off(s)",
			holds_done);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
